[rtl/lfpd_pkg.sv]
// Shared types and constants of the line follower PD and charge controller.
`default_nettype none
package lfpd_pkg;

  localparam int PwmMaxDefault = 1000;
  localparam int AluW          = 34;

  localparam logic [2:0] CFG_PAD_LEVEL        = 3'd0;
  localparam logic [2:0] CFG_CHARGE_MS        = 3'd1;
  localparam logic [2:0] CFG_DEPART_MS        = 3'd2;
  localparam logic [2:0] CFG_CRUISE_DUTY      = 3'd3;
  localparam logic [2:0] CFG_KP_GAIN          = 3'd4;
  localparam logic [2:0] CFG_KD_GAIN          = 3'd5;
  localparam logic [2:0] CFG_CORRECTION_LIMIT = 3'd6;

  localparam logic [11:0] AdcThresholdReset    = 12'd1200;
  localparam logic [31:0] ChargeTimeReset      = 32'd10000;
  localparam logic [31:0] LeaveTimeReset       = 32'd500;
  localparam logic [9:0]  BaseSpeedReset       = 10'd300;
  localparam logic [11:0] KpGainReset          = 12'd240;
  localparam logic [11:0] KdGainReset          = 12'd800;
  localparam logic [9:0]  CorrectionLimitReset = 10'd800;

  typedef enum logic [1:0] {
    MODE_TRACK  = 2'd0,
    MODE_CHARGE = 2'd1,
    MODE_LEAVE  = 2'd2
  } mode_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ELAPSED,
    S_CMP,
    S_SUM,
    S_ABS,
    S_DIV,
    S_SIGN,
    S_DIFF,
    S_MUL_P,
    S_MUL_D,
    S_ROUND,
    S_SAT_HI,
    S_SAT_LO,
    S_NEG_LIM,
    S_LEFT,
    S_RIGHT,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [11:0] pad_level;
    logic [31:0] charge_ms;
    logic [31:0] depart_ms;
    logic [9:0]  cruise_duty;
    logic [11:0] kp_gain;
    logic [11:0] kd_gain;
    logic [9:0]  correction_limit;
  } cfg_t;

  typedef struct packed {
    logic [AluW-1:0] a;
    logic [AluW-1:0] b;
    logic            sub;
  } alu_req_t;

  typedef struct packed {
    logic signed [11:0] left_wheel;
    logic signed [11:0] right_wheel;
    mode_t              mode;
    logic signed [10:0] corr;
  } seq_result_t;

endpackage
`default_nettype wire

[rtl/lfpd_alu.sv]
// Shared add/subtract unit with a sign flag, used by every step of the sequencer.
`default_nettype none
module lfpd_alu
  import lfpd_pkg::*;
(
  input  alu_req_t        req,
  output logic [AluW-1:0] res,
  output logic            neg
);

  assign res = req.sub ? (req.a - req.b) : (req.a + req.b);
  assign neg = res[AluW-1];

endmodule
`default_nettype wire

[rtl/lfpd_seq.sv]
// Sequencer and working registers that run one control tick through the shared adder.
`default_nettype none
module lfpd_seq
  import lfpd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [4:0]      sensor_bits,
  input  logic [11:0]     pad_sample,
  input  logic [31:0]     time_ms,
  input  cfg_t            cfg,
  input  logic            out_free,
  output logic            busy,
  output logic            load,
  output seq_result_t     result,
  output alu_req_t        alu_req,
  input  logic [AluW-1:0] alu_res,
  input  logic            alu_neg
);

  seq_state_t state, state_next;

  mode_t              mode;
  logic [31:0]        timer_start;
  logic signed [6:0]  prev_error;
  logic [31:0]        now;
  logic [31:0]        elapsed;
  logic [4:0]         sensors;
  logic [11:0]        pad;
  logic [3:0]         cnt;
  logic signed [7:0]  sum;
  logic [2:0]         count;
  logic               sum_neg;
  logic [5:0]         divq;
  logic [3:0]         rem;
  logic signed [6:0]  dev;
  logic signed [7:0]  diff;
  logic signed [19:0] mcand;
  logic [11:0]        mier;
  logic signed [21:0] acc;
  logic signed [17:0] cval;
  logic signed [11:0] wl;
  logic signed [11:0] wr;

  function automatic logic signed [7:0] weight(input logic [2:0] idx);
    case (idx)
      3'd0:    weight = 8'sd43;
      3'd1:    weight = 8'sd15;
      3'd3:    weight = -8'sd15;
      3'd4:    weight = -8'sd43;
      default: weight = 8'sd0;
    endcase
  endfunction

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (start) state_next = S_ELAPSED;
      S_ELAPSED: state_next = S_CMP;
      S_CMP: begin
        if (mode == MODE_TRACK && !alu_neg) state_next = S_SUM;
        else state_next = S_DONE;
      end
      S_SUM:     if (cnt == 4'd4) state_next = S_ABS;
      S_ABS: begin
        if (count == 3'd0) state_next = S_DIFF;
        else state_next = S_DIV;
      end
      S_DIV:     if (cnt == 4'd5) state_next = S_SIGN;
      S_SIGN:    state_next = S_DIFF;
      S_DIFF:    state_next = S_MUL_P;
      S_MUL_P:   if (cnt == 4'd11) state_next = S_MUL_D;
      S_MUL_D:   if (cnt == 4'd11) state_next = S_ROUND;
      S_ROUND:   state_next = S_SAT_HI;
      S_SAT_HI:  state_next = S_SAT_LO;
      S_SAT_LO: begin
        if (alu_neg) state_next = S_NEG_LIM;
        else state_next = S_LEFT;
      end
      S_NEG_LIM: state_next = S_LEFT;
      S_LEFT:    state_next = S_RIGHT;
      S_RIGHT:   state_next = S_DONE;
      S_DONE:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Operands of the shared adder for each step.
  always_comb begin
    alu_req = '0;
    case (state)
      S_ELAPSED: begin
        alu_req.a   = AluW'(now);
        alu_req.b   = AluW'(timer_start);
        alu_req.sub = 1'b1;
      end
      S_CMP: begin
        alu_req.sub = 1'b1;
        case (mode)
          MODE_TRACK: begin
            alu_req.a = AluW'(cfg.pad_level);
            alu_req.b = AluW'(pad);
          end
          MODE_CHARGE: begin
            alu_req.a = AluW'(cfg.charge_ms);
            alu_req.b = AluW'(elapsed);
          end
          MODE_LEAVE: begin
            alu_req.a = AluW'(cfg.depart_ms);
            alu_req.b = AluW'(elapsed);
          end
          default: begin
            alu_req.a = '0;
            alu_req.b = '0;
          end
        endcase
      end
      S_SUM: begin
        alu_req.a = AluW'(sum);
        alu_req.b = AluW'(weight(cnt[2:0]));
      end
      S_ABS: begin
        alu_req.b   = AluW'(sum);
        alu_req.sub = 1'b1;
      end
      S_DIV: begin
        alu_req.a   = AluW'({rem, divq[5]});
        alu_req.b   = AluW'(count);
        alu_req.sub = 1'b1;
      end
      S_SIGN: begin
        alu_req.b   = AluW'(divq);
        alu_req.sub = 1'b1;
      end
      S_DIFF: begin
        alu_req.a   = AluW'(dev);
        alu_req.b   = AluW'(prev_error);
        alu_req.sub = 1'b1;
      end
      S_MUL_P, S_MUL_D: begin
        alu_req.a = AluW'(acc);
        alu_req.b = AluW'(mcand);
      end
      S_ROUND: begin
        // Bias a negative sum so that the shift truncates toward zero.
        alu_req.a = AluW'(acc);
        alu_req.b = acc[21] ? AluW'(15) : '0;
      end
      S_SAT_HI: begin
        alu_req.a   = AluW'(cfg.correction_limit);
        alu_req.b   = AluW'(cval);
        alu_req.sub = 1'b1;
      end
      S_SAT_LO: begin
        alu_req.a = AluW'(cval);
        alu_req.b = AluW'(cfg.correction_limit);
      end
      S_NEG_LIM: begin
        alu_req.b   = AluW'(cfg.correction_limit);
        alu_req.sub = 1'b1;
      end
      S_LEFT: begin
        alu_req.a = AluW'(cfg.cruise_duty);
        alu_req.b = AluW'(cval);
      end
      S_RIGHT: begin
        alu_req.a   = AluW'(cfg.cruise_duty);
        alu_req.b   = AluW'(cval);
        alu_req.sub = 1'b1;
      end
      default: alu_req = '0;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign load = (state == S_DONE) && out_free;

  assign result.left_wheel  = wl;
  assign result.right_wheel = wr;
  assign result.mode        = mode;
  assign result.corr        = cval[10:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      mode        <= MODE_CHARGE;
      timer_start <= '0;
      prev_error  <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            sensors <= sensor_bits;
            pad     <= pad_sample;
            now     <= time_ms;
          end
        end
        S_ELAPSED: elapsed <= alu_res[31:0];
        S_CMP: begin
          wl    <= (mode == MODE_LEAVE) ? 12'(cfg.cruise_duty) : '0;
          wr    <= (mode == MODE_LEAVE) ? 12'(cfg.cruise_duty) : '0;
          cval  <= '0;
          sum   <= '0;
          count <= '0;
          cnt   <= '0;
          case (mode)
            MODE_TRACK: begin
              if (alu_neg) begin
                timer_start <= now;
                mode        <= MODE_CHARGE;
              end
            end
            MODE_CHARGE: begin
              if (alu_neg) begin
                timer_start <= now;
                mode        <= MODE_LEAVE;
              end
            end
            MODE_LEAVE: begin
              if (alu_neg) begin
                prev_error <= '0;
                mode       <= MODE_TRACK;
              end
            end
            default: ;
          endcase
        end
        S_SUM: begin
          if (sensors[cnt[2:0]]) begin
            sum   <= alu_res[7:0];
            count <= count + 3'd1;
          end
          cnt <= cnt + 4'd1;
        end
        S_ABS: begin
          sum_neg <= sum[7];
          divq    <= sum[7] ? alu_res[5:0] : sum[5:0];
          rem     <= '0;
          cnt     <= '0;
          // With no sensor on the line the error holds its last value.
          if (count == 3'd0) dev <= prev_error;
        end
        S_DIV: begin
          if (!alu_neg) begin
            rem  <= alu_res[3:0];
            divq <= {divq[4:0], 1'b1};
          end else begin
            rem  <= {rem[2:0], divq[5]};
            divq <= {divq[4:0], 1'b0};
          end
          cnt <= cnt + 4'd1;
        end
        S_SIGN: dev <= sum_neg ? alu_res[6:0] : {1'b0, divq};
        S_DIFF: begin
          diff  <= alu_res[7:0];
          mcand <= 20'(dev);
          mier  <= cfg.kp_gain;
          acc   <= '0;
          cnt   <= '0;
        end
        S_MUL_P, S_MUL_D: begin
          if (mier[0]) acc <= alu_res[21:0];
          if (state == S_MUL_P && cnt == 4'd11) begin
            mcand <= 20'(diff);
            mier  <= cfg.kd_gain;
            cnt   <= '0;
          end else begin
            mcand <= mcand <<< 1;
            mier  <= mier >> 1;
            cnt   <= cnt + 4'd1;
          end
        end
        S_ROUND: cval <= alu_res[21:4];
        S_SAT_HI: begin
          prev_error <= dev;
          if (alu_neg) cval <= 18'(cfg.correction_limit);
        end
        S_NEG_LIM: cval <= alu_res[17:0];
        S_LEFT:    wl <= alu_res[11:0];
        S_RIGHT:   wr <= alu_res[11:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/line_follower_pd_charge_controller.sv]
// A beat outside tracking skips the centroid, divide and multiply steps and goes straight to its result.
// One adder serves every step: the centroid sum, a 6-step divide and a 24-step shift-add multiply.
// A new beat is taken the cycle after the previous result enters the output register.
// Synchronous reset restores the register defaults and starts in charging mode with the
// timer start and the previous error at zero.
`default_nettype none
module line_follower_pd_charge_controller
  import lfpd_pkg::*;
#(
  parameter int PWM_MAX = PwmMaxDefault
)(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [4:0]         sensor_bits,
  input  logic [11:0]        pad_sample,
  input  logic [31:0]        time_ms,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [9:0]         left_fwd_duty,
  output logic [9:0]         left_rev_duty,
  output logic [9:0]         right_fwd_duty,
  output logic [9:0]         right_rev_duty,
  output logic [1:0]         mode_now,
  output logic signed [10:0] steer_correction,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic [15:0] PwmMaxVal = 16'(PWM_MAX);

  cfg_t        cfg;
  alu_req_t    alu_req;
  logic [AluW-1:0] alu_res;
  logic        alu_neg;
  logic        busy;
  logic        load;
  logic        out_free;
  seq_result_t res;
  logic [19:0] left_drive;
  logic [19:0] right_drive;

  // Clamp a wheel speed to the PWM range and split it into forward and reverse duties.
  function automatic logic [19:0] drive(input logic signed [11:0] speed,
                                        input logic [15:0] pmax);
    logic signed [16:0] s;
    logic signed [16:0] p;
    logic signed [16:0] c;
    logic signed [16:0] m;
    s = 17'(speed);
    p = signed'({1'b0, pmax});
    if (s > p) c = p;
    else if (s < -p) c = -p;
    else c = s;
    m = -c;
    if (c > 17'sd0) drive = {c[9:0], 10'd0};
    else if (c < 17'sd0) drive = {10'd0, m[9:0]};
    else drive = '0;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pad_level        <= AdcThresholdReset;
      cfg.charge_ms        <= ChargeTimeReset;
      cfg.depart_ms        <= LeaveTimeReset;
      cfg.cruise_duty      <= BaseSpeedReset;
      cfg.kp_gain          <= KpGainReset;
      cfg.kd_gain          <= KdGainReset;
      cfg.correction_limit <= CorrectionLimitReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PAD_LEVEL:        cfg.pad_level        <= cfg_data[11:0];
        CFG_CHARGE_MS:        cfg.charge_ms        <= cfg_data;
        CFG_DEPART_MS:        cfg.depart_ms        <= cfg_data;
        CFG_CRUISE_DUTY:      cfg.cruise_duty      <= cfg_data[9:0];
        CFG_KP_GAIN:          cfg.kp_gain          <= cfg_data[11:0];
        CFG_KD_GAIN:          cfg.kd_gain          <= cfg_data[11:0];
        CFG_CORRECTION_LIMIT: cfg.correction_limit <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  lfpd_alu u_alu (
    .req (alu_req),
    .res (alu_res),
    .neg (alu_neg)
  );

  lfpd_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (item_valid && !item_stall),
    .sensor_bits (sensor_bits),
    .pad_sample  (pad_sample),
    .time_ms     (time_ms),
    .cfg         (cfg),
    .out_free    (out_free),
    .busy        (busy),
    .load        (load),
    .result      (res),
    .alu_req     (alu_req),
    .alu_res     (alu_res),
    .alu_neg     (alu_neg)
  );

  assign item_stall = busy;
  assign out_free   = !result_valid || !result_stall;

  assign left_drive  = drive(res.left_wheel, PwmMaxVal);
  assign right_drive = drive(res.right_wheel, PwmMaxVal);

  // The output register holds a result until it is taken; the sequencer hands over a beat only when it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_fwd_duty    <= left_drive[19:10];
      left_rev_duty    <= left_drive[9:0];
      right_fwd_duty   <= right_drive[19:10];
      right_rev_duty   <= right_drive[9:0];
      mode_now         <= res.mode;
      steer_correction <= res.corr;
    end
  end

endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the line follower PD and charge pad controller.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lfpd_pkg::*;

  localparam int PwmMax     = PwmMaxDefault;
  localparam int QuietLimit = 3000;
  localparam int LineWeight [5] = '{43, 15, 0, -15, -43};
  // Kinds of register setting per phase: 0 high extremes, 1 low extremes,
  // 2 endless timers, anything else random.
  localparam int PhaseKind [9] = '{3, 0, 3, 1, 3, 2, 3, 3, 3};

  typedef struct packed {
    logic [9:0]         left_fwd;
    logic [9:0]         left_rev;
    logic [9:0]         right_fwd;
    logic [9:0]         right_rev;
    mode_t              mode;
    logic signed [10:0] corr;
  } wheel_cmd_t;

  class wheel_command_tracker;
    cfg_t        cfg;
    mode_t       mode;
    logic [31:0] timer_start;
    int          prev_error;
    wheel_cmd_t  due [$];
    int          ticks, checked, failures, pad_stops, leaves, saturated;

    function new();
      cfg.pad_level        = AdcThresholdReset;
      cfg.charge_ms        = ChargeTimeReset;
      cfg.depart_ms        = LeaveTimeReset;
      cfg.cruise_duty      = BaseSpeedReset;
      cfg.kp_gain          = KpGainReset;
      cfg.kd_gain          = KdGainReset;
      cfg.correction_limit = CorrectionLimitReset;
      mode        = MODE_CHARGE;
      timer_start = '0;
      prev_error  = 0;
      ticks = 0; checked = 0; failures = 0;
      pad_stops = 0; leaves = 0; saturated = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_PAD_LEVEL:        cfg.pad_level        = data[11:0];
        CFG_CHARGE_MS:        cfg.charge_ms        = data;
        CFG_DEPART_MS:        cfg.depart_ms        = data;
        CFG_CRUISE_DUTY:      cfg.cruise_duty      = data[9:0];
        CFG_KP_GAIN:          cfg.kp_gain          = data[11:0];
        CFG_KD_GAIN:          cfg.kd_gain          = data[11:0];
        CFG_CORRECTION_LIMIT: cfg.correction_limit = data[9:0];
        default: ;
      endcase
    endfunction

    // A signed wheel speed becomes a forward or a reverse duty, never both.
    function void split_speed(int speed, output logic [9:0] fwd, output logic [9:0] rev);
      int clamped;
      clamped = speed;
      if (clamped > PwmMax) clamped = PwmMax;
      if (clamped < -PwmMax) clamped = -PwmMax;
      fwd = (clamped > 0) ? 10'(clamped) : '0;
      rev = (clamped < 0) ? 10'(-clamped) : '0;
    endfunction

    function void take_tick(logic [4:0] sensors, logic [11:0] pad, logic [31:0] stamp);
      logic [31:0] elapsed;
      int          left, right, corr, sum, cnt, dev, total, lim;
      wheel_cmd_t  cmd;
      elapsed = stamp - timer_start;
      left = 0;
      right = 0;
      corr = 0;
      ticks++;
      case (mode)
        MODE_TRACK: begin
          if (pad > cfg.pad_level) begin
            timer_start = stamp;
            mode = MODE_CHARGE;
            pad_stops++;
          end else begin
            sum = 0;
            cnt = 0;
            for (int i = 0; i < 5; i++) begin
              if (sensors[i]) begin
                sum += LineWeight[i];
                cnt++;
              end
            end
            // With no line in sight the last deviation is held, so D is zero.
            dev = (cnt == 0) ? prev_error : sum / cnt;
            total = dev * int'(cfg.kp_gain) + (dev - prev_error) * int'(cfg.kd_gain);
            corr = total / 16;
            lim = int'(cfg.correction_limit);
            if (corr > lim || corr < -lim) saturated++;
            if (corr > lim) corr = lim;
            if (corr < -lim) corr = -lim;
            prev_error = dev;
            left = int'(cfg.cruise_duty) + corr;
            right = int'(cfg.cruise_duty) - corr;
          end
        end
        MODE_CHARGE: begin
          if (elapsed > cfg.charge_ms) begin
            timer_start = stamp;
            mode = MODE_LEAVE;
            leaves++;
          end
        end
        MODE_LEAVE: begin
          left = int'(cfg.cruise_duty);
          right = int'(cfg.cruise_duty);
          if (elapsed > cfg.depart_ms) begin
            prev_error = 0;
            mode = MODE_TRACK;
          end
        end
        default: ;
      endcase
      split_speed(left, cmd.left_fwd, cmd.left_rev);
      split_speed(right, cmd.right_fwd, cmd.right_rev);
      cmd.mode = mode;
      cmd.corr = corr[10:0];
      due.push_back(cmd);
    endfunction

    function void check_field(string name, longint want, longint seen);
      if (want != seen) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        failures++;
      end
    endfunction

    function void check_command(wheel_cmd_t got);
      wheel_cmd_t want;
      if (due.size() == 0) begin
        $error("wheel command with no tick waiting: mode %0d", got.mode);
        failures++;
      end else begin
        want = due.pop_front();
        checked++;
        check_field("left_fwd_duty", want.left_fwd, got.left_fwd);
        check_field("left_rev_duty", want.left_rev, got.left_rev);
        check_field("right_fwd_duty", want.right_fwd, got.right_fwd);
        check_field("right_rev_duty", want.right_rev, got.right_rev);
        check_field("mode_now", want.mode, got.mode);
        check_field("steer_correction", want.corr, got.corr);
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [4:0]         sensor_bits = '0;
  logic [11:0]        pad_sample = '0;
  logic [31:0]        time_ms = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [9:0]         left_fwd_duty, left_rev_duty, right_fwd_duty, right_rev_duty;
  logic [1:0]         mode_now;
  logic signed [10:0] steer_correction;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  wheel_command_tracker tracker;
  wheel_cmd_t           seen_cmd;
  int                   quiet_cycles = 0;
  int                   burst_left = 0;
  bit                   gaps_on = 1'b0;
  int                   stall_run = 0;
  int                   stall_kind = 0;
  int                   settings = 0;

  line_follower_pd_charge_controller uut (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .sensor_bits      (sensor_bits),
    .pad_sample       (pad_sample),
    .time_ms          (time_ms),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .left_fwd_duty    (left_fwd_duty),
    .left_rev_duty    (left_rev_duty),
    .right_fwd_duty   (right_fwd_duty),
    .right_rev_duty   (right_rev_duty),
    .mode_now         (mode_now),
    .steer_correction (steer_correction),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) begin
      tracker.take_tick(sensor_bits, pad_sample, time_ms);
    end
    if (!rst && result_valid && !result_stall) begin
      seen_cmd.left_fwd  = left_fwd_duty;
      seen_cmd.left_rev  = left_rev_duty;
      seen_cmd.right_fwd = right_fwd_duty;
      seen_cmd.right_rev = right_rev_duty;
      seen_cmd.mode      = mode_t'(mode_now);
      seen_cmd.corr      = steer_correction;
      tracker.check_command(seen_cmd);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("line_follower_pd_charge_controller regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The result side stalls in stretches: none, light, heavy or solid.
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_kind = $urandom_range(0, 3);
      stall_run = $urandom_range(1, 60);
    end
    stall_run = stall_run - 1;
    case (stall_kind)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 3) == 0);
      2: result_stall <= ($urandom_range(0, 3) != 0);
      default: result_stall <= 1'b1;
    endcase
  end

  task automatic send_tick(input logic [4:0] bits_in, input logic [11:0] pad_in,
                           input logic [31:0] stamp_in);
    if (burst_left == 0) begin
      if (gaps_on) begin
        @(negedge clk);
        item_valid <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    item_valid  <= 1'b1;
    sensor_bits <= bits_in;
    pad_sample  <= pad_in;
    time_ms     <= stamp_in;
    do @(posedge clk); while (item_stall);
    burst_left--;
  endtask

  // Hold the sender off until every pending command has come back.
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, data);
  endtask

  initial begin
    cfg_t        s;
    logic [31:0] now_ms;
    logic [4:0]  bits;
    logic [11:0] pad;
    int          n_items, pause_at, r, lane;

    tracker = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed ticks under the reset settings: charge timer boundary, leave
    // timer boundary, a set of centroid shapes, threshold edge and timer wrap.
    send_tick(5'b00000, 12'd0, 32'd0);
    send_tick(5'b11111, 12'd4095, 32'd10000);
    send_tick(5'b00000, 12'd0, 32'd10001);
    send_tick(5'b00000, 12'd0, 32'd10501);
    send_tick(5'b00000, 12'd0, 32'd10502);
    send_tick(5'b00001, 12'd1200, 32'd10510);
    send_tick(5'b10000, 12'd0, 32'd10520);
    send_tick(5'b00000, 12'd0, 32'd10530);
    send_tick(5'b11111, 12'd0, 32'd10540);
    send_tick(5'b00011, 12'd100, 32'd10550);
    send_tick(5'b11000, 12'd100, 32'd10560);
    send_tick(5'b00110, 12'd100, 32'd10570);
    send_tick(5'b01100, 12'd100, 32'd10580);
    send_tick(5'b10101, 12'd100, 32'd10590);
    send_tick(5'b00111, 12'd100, 32'd10600);
    send_tick(5'b11100, 12'd100, 32'd10610);
    send_tick(5'b00100, 12'd100, 32'd10620);
    send_tick(5'b01000, 12'd1201, 32'hFFFF_FFF0);
    send_tick(5'b00010, 12'd4095, 32'd9984);
    send_tick(5'b00000, 12'd4095, 32'd9985);
    send_tick(5'b00000, 12'd0, 32'd10485);
    send_tick(5'b00001, 12'd0, 32'hFFFF_FFFF);
    send_tick(5'b10000, 12'd4095, 32'hFFFF_FFFF);
    now_ms = 32'hFFFF_FFFF;

    for (int ph = 0; ph < 9; ph++) begin
      drain();
      s.pad_level        = $urandom_range(0, 4095);
      s.charge_ms        = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 300);
      s.depart_ms        = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 300);
      s.cruise_duty      = $urandom_range(0, 1000);
      s.kp_gain          = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 400);
      s.kd_gain          = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 400);
      s.correction_limit = $urandom_range(0, 1000);
      case (PhaseKind[ph])
        0: begin
          s.pad_level = 12'd4095;
          s.charge_ms = '0;
          s.depart_ms = '0;
          s.cruise_duty = 10'd1000;
          s.kp_gain = 12'd4095;
          s.kd_gain = 12'd4095;
          s.correction_limit = 10'd1000;
        end
        1: s = '0;
        2: begin
          s.charge_ms = 32'hFFFF_FFFF;
          s.depart_ms = 32'hFFFF_FFFF;
        end
        default: ;
      endcase
      write_reg(CFG_PAD_LEVEL, 32'(s.pad_level));
      write_reg(CFG_CHARGE_MS, s.charge_ms);
      write_reg(CFG_DEPART_MS, s.depart_ms);
      write_reg(CFG_CRUISE_DUTY, 32'(s.cruise_duty));
      write_reg(CFG_KP_GAIN, 32'(s.kp_gain));
      write_reg(CFG_KD_GAIN, 32'(s.kd_gain));
      write_reg(CFG_CORRECTION_LIMIT, 32'(s.correction_limit));
      @(negedge clk);
      cfg_valid <= 1'b0;
      settings++;

      gaps_on = ($urandom_range(0, 3) != 0);
      n_items = (PhaseKind[ph] == 2) ? 40 : 95;
      pause_at = $urandom_range(10, n_items - 10);
      for (int k = 0; k < n_items; k++) begin
        if (k == pause_at) drain();
        // Mostly a steadily advancing clock, with the odd jump or step back
        // so that elapsed times wrap.
        r = $urandom_range(0, 99);
        if (r < 80) now_ms += $urandom_range(0, 40);
        else if (r < 92) now_ms += $urandom_range(0, 400);
        else if (r < 97) now_ms = $urandom;
        else now_ms -= $urandom_range(1, 50);
        r = $urandom_range(0, 99);
        lane = $urandom_range(0, 4);
        if (r < 60) bits = $urandom_range(0, 1) ? 5'(1 << lane) : 5'(3 << lane);
        else if (r < 88) bits = $urandom_range(0, 31);
        else bits = '0;
        if ($urandom_range(0, 99) < 4 && s.pad_level != 12'd4095) begin
          pad = $urandom_range(int'(s.pad_level) + 1, 4095);
        end else begin
          pad = $urandom_range(0, int'(s.pad_level));
        end
        send_tick(bits, pad, now_ms);
      end
    end
    drain();

    $display("Covered %0d ticks and %0d checked wheel commands over %0d register settings,",
             tracker.ticks, tracker.checked, settings);
    $display("with %0d pad stops, %0d charge exits and %0d saturated corrections.",
             tracker.pad_stops, tracker.leaves, tracker.saturated);
    if (tracker.failures == 0) begin
      $display("line_follower_pd_charge_controller regression: pass");
    end else begin
      $display("line_follower_pd_charge_controller regression: fail");
    end
    $finish;
  end
endmodule
